@@ rtl/smep_pkg.sv @@
// Shared types, codes and constants of the scroll message escape parser.
package smep_pkg;

    localparam int ANIM_SLOTS = 16;

    localparam logic [7:0] CH_TILDE      = 8'h7E;
    localparam logic [7:0] CH_CARET      = 8'h5E;
    localparam logic [7:0] CH_RAW_MARK   = 8'hFF;
    localparam logic [7:0] CH_ANIM_BASE  = 8'h41;
    localparam logic [7:0] CARET_OFFSET_RESET = 8'd63;

    typedef enum logic [2:0] {
        ACT_SETMODE = 3'd0,
        ACT_CLEAR   = 3'd1,
        ACT_CHAR    = 3'd2,
        ACT_RAW     = 3'd3,
        ACT_ANIM    = 3'd4,
        ACT_END     = 3'd5,
        ACT_WRAP    = 3'd6
    } action_t;

    typedef enum logic [4:0] {
        PH_MODE  = 5'b00001,
        PH_BODY  = 5'b00010,
        PH_TILDE = 5'b00100,
        PH_CARET = 5'b01000,
        PH_RAW   = 5'b10000
    } phase_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] value;
        logic       step_five;
        logic       bidirectional;
        logic [2:0] delay_index;
        logic [2:0] speed_index;
        logic       last;
    } result_t;

    typedef struct packed {
        result_t    r0;
        result_t    r1;
        logic [1:0] cnt;
    } parse_out_t;

    function automatic result_t mk_result(action_t act, logic [7:0] val);
        result_t r;
        r        = '0;
        r.action = act;
        r.value  = val;
        return r;
    endfunction

endpackage

@@ rtl/scroll_message_escape_parser_core.sv @@
// Top level of the scroll message escape parser: input register, decode, result queue.
//
// channel | direction | tdata                                   | tuser      | tlast
// s_      | in        | [7:0] message_byte                      | -          | -
// m_      | out       | [7:0] value [8] step_five [9] bidirect. | [2:0] act. | last
//         |           | [12:10] delay_index [15:13] speed_index |            |
// cfg_    | in        | cfg_wdata [7:0] caret_offset, cfg_wen   |            |
//
// One byte is decoded per cycle while the queue has room for two results; a byte may push
// two results at once, and the output gives one transfer per cycle while m_tready is high.
// Path: input register, then combinational decode written into the four-entry result queue.
// Reset (aresetn low, synchronous) empties the queue and returns to expecting a mode byte.
// A stalled m_ side back-pressures s_ once the queue cannot take two more results.
module scroll_message_escape_parser_core
    import smep_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] message_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // value, step_five, bidirectional, delay_index, speed_index
    output logic [2:0]  m_tuser,   // action
    output logic        m_tlast,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       room2;
    logic       fire;
    parse_out_t pout;
    result_t    head;

    assign fire     = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    smep_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_in   (in_byte_reg),
        .fire      (fire),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .pout      (pout)
    );

    smep_res_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fire),
        .pin        (pout),
        .room2      (room2),
        .head       (head),
        .head_valid (m_tvalid),
        .pop        (m_tready)
    );

    assign m_tdata = {head.speed_index, head.delay_index, head.bidirectional,
                      head.step_five, head.value};
    assign m_tuser = head.action;
    assign m_tlast = head.last;

endmodule

@@ rtl/smep_parser.sv @@
// Parse state, caret offset register and per-byte result decode.
module smep_parser
    import smep_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] byte_in,
    input  logic       fire,
    input  logic       cfg_wen,
    input  logic [7:0] cfg_wdata,
    output parse_out_t pout
);

    localparam logic [8:0] ANIM_SLOTS_W = 9'(ANIM_SLOTS);

    phase_t     phase_reg, phase_next;
    logic       seen_reg, seen_next;
    logic [7:0] caret_reg;
    logic [7:0] anim_idx;
    result_t    r0, r1;
    logic [1:0] n;

    assign anim_idx = byte_in - CH_ANIM_BASE;

    always_comb begin
        r0         = '0;
        r1         = '0;
        n          = 2'd0;
        phase_next = phase_reg;
        seen_next  = seen_reg;
        unique case (phase_reg)
            PH_BODY: begin
                if (byte_in == 8'd0) begin
                    r0         = mk_result(ACT_END, 8'd0);
                    n          = 2'd1;
                    phase_next = PH_MODE;
                    seen_next  = 1'b0;
                end else begin
                    if (seen_reg) begin
                        r0 = mk_result(ACT_RAW, 8'd0);
                        n  = 2'd1;
                    end
                    seen_next = 1'b1;
                    if (byte_in == CH_TILDE) begin
                        phase_next = PH_TILDE;
                    end else if (byte_in == CH_RAW_MARK) begin
                        phase_next = PH_RAW;
                    end else if (byte_in == CH_CARET) begin
                        phase_next = PH_CARET;
                    end else if (seen_reg) begin
                        r1 = mk_result(ACT_CHAR, byte_in);
                        n  = 2'd2;
                    end else begin
                        r0 = mk_result(ACT_CHAR, byte_in);
                        n  = 2'd1;
                    end
                end
            end
            PH_TILDE: begin
                if (byte_in != CH_TILDE && {1'b0, anim_idx} < ANIM_SLOTS_W) begin
                    r0 = mk_result(ACT_ANIM, anim_idx);
                    n  = 2'd1;
                end
                phase_next = PH_BODY;
            end
            PH_CARET: begin
                r0 = mk_result(ACT_CHAR,
                               (byte_in == CH_CARET) ? byte_in : byte_in + caret_reg);
                n          = 2'd1;
                phase_next = PH_BODY;
            end
            PH_RAW: begin
                if (byte_in == CH_RAW_MARK) begin
                    phase_next = PH_BODY;
                end else begin
                    r0 = mk_result(ACT_RAW, byte_in);
                    n  = 2'd1;
                end
            end
            default: begin
                if (byte_in == 8'd0) begin
                    r0         = mk_result(ACT_WRAP, 8'd0);
                    n          = 2'd1;
                    phase_next = PH_MODE;
                end else begin
                    r0               = mk_result(ACT_SETMODE, 8'd0);
                    r0.step_five     = byte_in[3];
                    r0.bidirectional = byte_in[7];
                    r0.delay_index   = byte_in[6:4];
                    r0.speed_index   = byte_in[2:0];
                    r1               = mk_result(ACT_CLEAR, 8'd0);
                    n                = 2'd2;
                    phase_next       = PH_BODY;
                end
                seen_next = 1'b0;
            end
        endcase
        if (n == 2'd1) begin
            r0.last = 1'b1;
        end
        if (n == 2'd2) begin
            r1.last = 1'b1;
        end
    end

    assign pout.r0  = r0;
    assign pout.r1  = r1;
    assign pout.cnt = n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MODE;
            seen_reg  <= 1'b0;
            caret_reg <= CARET_OFFSET_RESET;
        end else begin
            if (fire) begin
                phase_reg <= phase_next;
                seen_reg  <= seen_next;
            end
            if (cfg_wen) begin
                caret_reg <= cfg_wdata;
            end
        end
    end

endmodule

@@ rtl/smep_res_fifo.sv @@
// Four-entry result queue, up to two writes and one read per cycle.
module smep_res_fifo
    import smep_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  parse_out_t pin,
    output logic       room2,
    output result_t    head,
    output logic       head_valid,
    input  logic       pop
);

    result_t    mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic [1:0] n_push;
    logic       do_pop;

    assign n_push     = push ? pin.cnt : 2'd0;
    assign do_pop     = pop && head_valid;
    assign head_valid = (count_reg != 3'd0);
    assign head       = mem[rd_ptr_reg];
    assign room2      = (count_reg <= 3'd2);

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem[wr_ptr_reg] <= pin.r0;
        end
        if (n_push == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= pin.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_push;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, do_pop};
            count_reg  <= count_reg + {1'b0, n_push} - {2'b00, do_pop};
        end
    end

endmodule

@@ dv/tb_scroll_message_escape_parser_core.sv @@
// Self-checking testbench for the scroll message escape parser core.
`timescale 1ns / 1ps

module tb_scroll_message_escape_parser_core;
    import smep_pkg::*;

    localparam int TAIL_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tready  = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    result_t     pending_cmds [$];
    result_t     oldest_cmd;
    phase_t      parse_ph    = PH_MODE;
    logic        in_element  = 1'b0;
    logic [7:0]  offset_cfg  = CARET_OFFSET_RESET;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_left    = 0;
    int bytes_sent   = 0;
    int cmds_checked = 0;
    int mismatches   = 0;

    scroll_message_escape_parser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #(12 * 400000);
        $display("tb_scroll_message_escape_parser_core NOT OK");
        $finish;
    end

    function automatic void decode_byte(input logic [7:0] b);
        result_t    cmd [2];
        int         n;
        logic [7:0] idx;
        n      = 0;
        cmd[0] = '0;
        cmd[1] = '0;
        unique case (parse_ph)
            PH_BODY: begin
                if (b == 8'h00) begin
                    cmd[n].action = ACT_END;
                    n++;
                    parse_ph   = PH_MODE;
                    in_element = 1'b0;
                end else begin
                    if (in_element) begin
                        cmd[n].action = ACT_RAW;
                        n++;
                    end
                    in_element = 1'b1;
                    if (b == CH_TILDE) begin
                        parse_ph = PH_TILDE;
                    end else if (b == CH_RAW_MARK) begin
                        parse_ph = PH_RAW;
                    end else if (b == CH_CARET) begin
                        parse_ph = PH_CARET;
                    end else begin
                        cmd[n].action = ACT_CHAR;
                        cmd[n].value  = b;
                        n++;
                    end
                end
            end
            PH_TILDE: begin
                if (b != CH_TILDE) begin
                    idx = b - CH_ANIM_BASE;
                    if (idx < ANIM_SLOTS) begin
                        cmd[n].action = ACT_ANIM;
                        cmd[n].value  = idx;
                        n++;
                    end
                end
                parse_ph = PH_BODY;
            end
            PH_CARET: begin
                cmd[n].action = ACT_CHAR;
                cmd[n].value  = (b == CH_CARET) ? b : b + offset_cfg;
                n++;
                parse_ph = PH_BODY;
            end
            PH_RAW: begin
                if (b == CH_RAW_MARK) begin
                    parse_ph = PH_BODY;
                end else begin
                    cmd[n].action = ACT_RAW;
                    cmd[n].value  = b;
                    n++;
                end
            end
            default: begin
                if (b == 8'h00) begin
                    cmd[n].action = ACT_WRAP;
                    n++;
                    parse_ph = PH_MODE;
                end else begin
                    cmd[0].action        = ACT_SETMODE;
                    cmd[0].step_five     = b[3];
                    cmd[0].bidirectional = b[7];
                    cmd[0].delay_index   = b[6:4];
                    cmd[0].speed_index   = b[2:0];
                    cmd[1].action        = ACT_CLEAR;
                    n = 2;
                    parse_ph = PH_BODY;
                end
                in_element = 1'b0;
            end
        endcase
        if (n > 0) cmd[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_cmds.push_back(cmd[i]);
    endfunction

    function automatic void check_field(input string name, input int unsigned expd,
                                        input int unsigned got);
        if (expd != got) begin
            $error("%s: expected %0d, got %0d", name, expd, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cmds.size() == 0) begin
                $error("command with none expected: action %0d value %0d", m_tuser, m_tdata[7:0]);
                mismatches++;
            end else begin
                oldest_cmd = pending_cmds.pop_front();
                check_field("action", oldest_cmd.action, m_tuser);
                check_field("value", oldest_cmd.value, m_tdata[7:0]);
                check_field("step_five", oldest_cmd.step_five, m_tdata[8]);
                check_field("bidirectional", oldest_cmd.bidirectional, m_tdata[9]);
                check_field("delay_index", oldest_cmd.delay_index, m_tdata[12:10]);
                check_field("speed_index", oldest_cmd.speed_index, m_tdata[15:13]);
                check_field("last", oldest_cmd.last, m_tlast);
                cmds_checked++;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_offset(input logic [7:0] v);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen    <= 1'b0;
        offset_cfg  = v;
    endtask

    task automatic send_message(input bit broken);
        int         n_elem;
        int         kind;
        logic [7:0] b;
        if ($urandom_range(99) < 8) begin
            send_byte(8'h00);
            return;
        end
        send_byte(8'($urandom_range(1, 255)));
        n_elem = $urandom_range(0, 7);
        repeat (n_elem) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                do b = 8'($urandom_range(1, 254)); while (b == CH_TILDE || b == CH_CARET);
                send_byte(b);
            end else if (kind < 60) begin
                send_byte(CH_CARET);
                send_byte(($urandom_range(99) < 15) ? CH_CARET : 8'($urandom_range(255)));
            end else if (kind < 80) begin
                send_byte(CH_TILDE);
                kind = $urandom_range(99);
                if (kind < 70) send_byte(CH_ANIM_BASE + 8'($urandom_range(ANIM_SLOTS - 1)));
                else if (kind < 80) send_byte(CH_TILDE);
                else send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(CH_RAW_MARK);
                repeat ($urandom_range(0, 4)) begin
                    do b = 8'($urandom_range(255)); while (b == CH_RAW_MARK);
                    send_byte(b);
                end
                send_byte(CH_RAW_MARK);
            end
        end
        if (broken) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
        end else begin
            send_byte(8'h00);
        end
    endtask

    task automatic test_directed_escapes();
        logic [7:0] seq [$];
        seq = '{8'h00, 8'hFF, 8'h48, CH_CARET, 8'h61, CH_CARET, CH_CARET,
                CH_TILDE, CH_ANIM_BASE, CH_TILDE, 8'h50, CH_TILDE, 8'h51,
                CH_TILDE, CH_TILDE, CH_TILDE, 8'h00, CH_CARET, 8'h00,
                CH_RAW_MARK, 8'h00, 8'h80, CH_RAW_MARK, 8'h00, 8'h08, 8'h00};
        foreach (seq[i]) send_byte(seq[i]);
        wait_drained();
    endtask

    task automatic test_offset_extremes();
        logic [7:0] offs [2];
        offs = '{8'h00, 8'hFF};
        foreach (offs[k]) begin
            write_offset(offs[k]);
            send_byte(8'h08);
            send_byte(CH_CARET);
            send_byte(8'h00);
            send_byte(CH_CARET);
            send_byte(8'hFF);
            send_byte(CH_CARET);
            send_byte(CH_ANIM_BASE);
            send_byte(8'h00);
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        write_offset(CARET_OFFSET_RESET);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_left    = HOLD_CYCLES;
        repeat (6) send_message(1'b0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic [7:0] offs, input int count);
        int start;
        int kind;
        write_offset(offs);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        start        = bytes_sent;
        while (bytes_sent - start < count) begin
            kind = $urandom_range(99);
            if (kind < 8) send_byte(8'($urandom_range(255)));
            else if (kind < 14) send_message(1'b1);
            else send_message(1'b0);
        end
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_directed_escapes();
        test_offset_extremes();
        test_output_backpressure();
        test_random_traffic(0, 0, CARET_OFFSET_RESET, 85);
        test_random_traffic(74, 0, 8'($urandom_range(255)), 85);
        test_random_traffic(0, 74, 8'hFF, 85);
        test_random_traffic(18, 18, 8'($urandom_range(255)), 85);
        wait_drained();
        $display("Sent %0d message bytes and checked %0d display commands", bytes_sent,
                 cmds_checked);
        $display("across escapes, offset extremes, a long output hold-off and four pacing mixes");
        if (mismatches == 0) begin
            $display("tb_scroll_message_escape_parser_core OK");
        end else begin
            $display("tb_scroll_message_escape_parser_core NOT OK");
        end
        $finish;
    end

endmodule
